// File: hw/rtl/sound_dsp_command_interface_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sound DSP command interface
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SOUND_DSP_COMMAND_INTERFACE_CORE_MACROS_SVH
`define SOUND_DSP_COMMAND_INTERFACE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition holds at every edge outside reset.
`define SDCI_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sdci check failed");
// Antecedent implies consequent at the next edge.
`define SDCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdci check failed");
`else
`define SDCI_ASSERT(label, cond)
`define SDCI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/sdci_pkg.sv
// ----------------------------------------------------------------------------
// sdci_pkg
// Types and constants shared by the DSP command interface modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdci_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned SAMPLES_W   = LENGTH_BITS + 1;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [9:0] BASE_RESET  = 10'h220;

  localparam logic [9:0] OFS_RESET   = 10'h006;
  localparam logic [9:0] OFS_READ    = 10'h00A;
  localparam logic [9:0] OFS_CMD     = 10'h00C;
  localparam logic [9:0] OFS_STATUS  = 10'h00E;

  localparam logic [7:0] RESET_REPLY = 8'hAA;
  localparam logic [7:0] CMD_TC      = 8'h40;
  localparam logic [7:0] CMD_PLAY    = 8'h14;
  localparam logic [7:0] CMD_PAUSE   = 8'hD0;
  localparam logic [7:0] CMD_SPK_ON  = 8'hD1;
  localparam logic [7:0] CMD_SPK_OFF = 8'hD3;
  localparam logic [7:0] FLAG_BIT    = 8'h80;
  localparam logic [7:0] LOW_BITS    = 8'h7F;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] DAC_MID     = 8'h80;

  typedef enum logic [1:0] {
    ACT_IO_WRITE = 2'd0,
    ACT_IO_READ  = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DMA      = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RST_SET,
    OP_RST_CLR,
    OP_CMD_WR,
    OP_RD_DATA,
    OP_RD_STATUS,
    OP_RD_CMD,
    OP_TICK,
    OP_SAMPLE
  } op_e;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] port_address;
    logic [7:0] write_data;
    logic [7:0] sample_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dma_request;
    logic [7:0] dac_value;
    logic       dac_update;
    logic       playing;
    logic       speaker_on;
  } out_item_t;

  // One classified beat waiting for the back end.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/sdci_front.sv
// ----------------------------------------------------------------------------
// sdci_front
// Accepts input beats, decodes the register offset and classifies each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdci_front import sdci_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  input  logic [9:0] base_port_i,
  input  q_stat_t   q_stat_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic [9:0] ofs;

  assign ofs        = in_item_i.port_address - base_port_i;
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.data = in_item_i.write_data;
    unique case (action_e'(in_item_i.action))
      ACT_IO_WRITE: begin
        if (ofs == OFS_RESET) begin
          cmd_o.op = in_item_i.write_data[0] ? OP_RST_SET : OP_RST_CLR;
        end else if (ofs == OFS_CMD) begin
          cmd_o.op = OP_CMD_WR;
        end
      end
      ACT_IO_READ: begin
        if (ofs == OFS_READ) begin
          cmd_o.op = OP_RD_DATA;
        end else if (ofs == OFS_STATUS) begin
          cmd_o.op = OP_RD_STATUS;
        end else if (ofs == OFS_CMD) begin
          cmd_o.op = OP_RD_CMD;
        end
      end
      ACT_TICK: begin
        cmd_o.op = OP_TICK;
      end
      ACT_DMA: begin
        cmd_o.op   = OP_SAMPLE;
        cmd_o.data = in_item_i.sample_byte;
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sdci_queue.sv
// ----------------------------------------------------------------------------
// sdci_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sound_dsp_command_interface_core_macros.svh"

module sdci_queue import sdci_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `SDCI_ASSERT(a_count_range, count_q <= QCNT_W'(QDEPTH))
  `SDCI_ASSERT(a_no_overflow, !(push_i && stat_o.full))
  `SDCI_ASSERT(a_no_underflow, !(pop_i && stat_o.empty))

endmodule

// File: hw/rtl/sdci_back.sv
// ----------------------------------------------------------------------------
// sdci_back
// Executes classified beats on the DSP state and registers each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sound_dsp_command_interface_core_macros.svh"

module sdci_back import sdci_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      head_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                 reset_held_q, reset_held_d;
  logic                 data_ready_q, data_ready_d;
  logic [7:0]           data_out_q, data_out_d;
  logic [7:0]           pending_q, pending_d;
  logic [1:0]           params_q, params_d;
  logic [7:0]           len_low_q, len_low_d;
  logic [7:0]           tc_q, tc_d;
  logic [SAMPLES_W-1:0] samples_q, samples_d;
  logic [8:0]           period_q, period_d;
  logic                 play_q, play_d;
  logic                 spk_q, spk_d;
  logic [7:0]           dac_q, dac_d;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic [8:0]             reload;
  logic [15:0]            len_word;
  logic [LENGTH_BITS-1:0] len_masked;

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign reload     = 9'd256 - {1'b0, tc_q};
  assign len_word   = {head_i.data, len_low_q};
  assign len_masked = len_word[LENGTH_BITS-1:0];

  always_comb begin
    reset_held_d = reset_held_q;
    data_ready_d = data_ready_q;
    data_out_d   = data_out_q;
    pending_d    = pending_q;
    params_d     = params_q;
    len_low_d    = len_low_q;
    tc_d         = tc_q;
    samples_d    = samples_q;
    period_d     = period_q;
    play_d       = play_q;
    spk_d        = spk_q;
    dac_d        = dac_q;
    out_d.read_data   = IDLE_BYTE;
    out_d.dma_request = 1'b0;
    out_d.dac_update  = 1'b0;
    unique case (head_i.op)
      OP_RST_SET: begin
        reset_held_d = 1'b1;
        data_ready_d = 1'b0;
      end
      OP_RST_CLR: begin
        if (reset_held_q) begin
          reset_held_d = 1'b0;
          pending_d    = '0;
          params_d     = '0;
          play_d       = 1'b0;
          spk_d        = 1'b0;
          data_out_d   = RESET_REPLY;
          data_ready_d = 1'b1;
        end
      end
      OP_CMD_WR: begin
        if (!reset_held_q) begin
          if (params_q != 2'd0) begin
            if (pending_q == CMD_TC) begin
              tc_d     = head_i.data;
              params_d = 2'd0;
            end else if (pending_q == CMD_PLAY && params_q == 2'd2) begin
              len_low_d = head_i.data;
              params_d  = 2'd1;
            end else begin
              samples_d = SAMPLES_W'(len_masked) + 1'b1;
              period_d  = reload;
              play_d    = 1'b1;
              params_d  = 2'd0;
            end
          end else begin
            case (head_i.data)
              CMD_TC: begin
                pending_d = head_i.data;
                params_d  = 2'd1;
              end
              CMD_PLAY: begin
                pending_d = head_i.data;
                params_d  = 2'd2;
              end
              CMD_PAUSE:   play_d = 1'b0;
              CMD_SPK_ON:  spk_d  = 1'b1;
              CMD_SPK_OFF: spk_d  = 1'b0;
              default: begin
              end
            endcase
          end
        end
      end
      OP_RD_DATA: begin
        out_d.read_data = data_out_q;
        data_ready_d    = 1'b0;
      end
      OP_RD_STATUS: begin
        out_d.read_data = (data_ready_q ? FLAG_BIT : 8'h00) | LOW_BITS;
      end
      OP_RD_CMD: begin
        out_d.read_data = LOW_BITS;
      end
      OP_TICK: begin
        if (play_q) begin
          if (period_q <= 9'd1) begin
            out_d.dma_request = 1'b1;
            period_d          = reload;
          end else begin
            period_d = period_q - 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        if (play_q && samples_q != '0) begin
          dac_d            = head_i.data;
          out_d.dac_update = 1'b1;
          samples_d        = samples_q - 1'b1;
          if (samples_q == SAMPLES_W'(1)) begin
            play_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    out_d.dac_value  = dac_d;
    out_d.playing    = play_d;
    out_d.speaker_on = spk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_held_q <= 1'b0;
      data_ready_q <= 1'b0;
      data_out_q   <= '0;
      pending_q    <= '0;
      params_q     <= '0;
      len_low_q    <= '0;
      tc_q         <= '0;
      samples_q    <= '0;
      period_q     <= '0;
      play_q       <= 1'b0;
      spk_q        <= 1'b0;
      dac_q        <= DAC_MID;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        reset_held_q <= reset_held_d;
        data_ready_q <= data_ready_d;
        data_out_q   <= data_out_d;
        pending_q    <= pending_d;
        params_q     <= params_d;
        len_low_q    <= len_low_d;
        tc_q         <= tc_d;
        samples_q    <= samples_d;
        period_q     <= period_d;
        play_q       <= play_d;
        spk_q        <= spk_d;
        dac_q        <= dac_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  `SDCI_ASSERT(a_params_range, params_q != 2'd3)
  `SDCI_ASSERT(a_params_cmd, (params_q == 2'd0) || (pending_q == CMD_TC) || (pending_q == CMD_PLAY))
  `SDCI_ASSERT(a_play_has_samples, !play_q || (samples_q != '0))
  `SDCI_ASSERT_NEXT(a_pop_loads, pop_o, out_valid_q)

endmodule

// File: hw/rtl/sound_dsp_command_interface_core.sv
// Flow: an accepted beat is queued, then popped and its result registered.
// Throughput: one beat per cycle while results are taken, set by the state
// update in the back end; a two-entry queue and output register absorb stalls.
// Reset: rst_ni is asynchronous and active low; it clears the queue, the DSP
// state (DAC held at mid-scale 0x80) and sets the base port to 0x220.
// ----------------------------------------------------------------------------
// sound_dsp_command_interface_core
// DSP command interface of an 8-bit PC sound card with single-cycle DMA.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sound_dsp_command_interface_core import sdci_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Base port register
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  // Event beats: io write, io read, microsecond tick, DMA sample
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  // Result beats, one per event
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  // Base of the register window; offsets are taken modulo 1024 against it.
  logic [9:0] base_port_q;

  // Front to queue
  logic    push;
  cmd_t    push_cmd;
  // Queue to back
  cmd_t    head;
  q_stat_t q_stat;
  logic    pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_port_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_port_q <= cfg_wdata_i;
    end
  end

  // Front end: takes a beat whenever the queue has room and tags it with the
  // decoded operation, so the back end never sees raw addresses.
  sdci_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .base_port_i (base_port_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Two entries keep the front accepting at full rate while the back end
  // drains, and let a stalled result not block the input on the same cycle.
  sdci_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Back end: command parser, reset handshake, playback counters and DAC.
  // It pops one beat per cycle whenever its output register is free.
  sdci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/sound_dsp_command_interface_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_dsp_command_interface_core_tb
// Self-checking bench for the DSP command interface. A directed table covers
// the reset handshake, the status and data ports, every command and the DMA
// playback path. Random bursts of well-formed command and playback sequences
// follow, mixed with noise, over several base-port settings. Every result
// beat is checked field by field against an in-bench DSP model or a pinned value.
// ----------------------------------------------------------------------------

module sound_dsp_command_interface_core_tb import sdci_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_PCT    = 38;
  localparam logic [SAMPLES_W-1:0] ONE_SAMPLE = 1;

  // A response fixed by hand in the directed table overrides the model's one.
  typedef struct {
    bit        pinned;
    out_item_t val;
  } typed_resp_t;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t val;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input has a known value from time 0
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [9:0] cfg_wdata_i = BASE_RESET;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  always #2 clk_i = ~clk_i;

  sound_dsp_command_interface_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // --------------------------------------------------------------------------
  // DSP model state (mirrors the block's registers)
  // --------------------------------------------------------------------------
  logic [9:0]           base_q;
  logic                 rst_held;
  logic                 ready_flag;
  logic [7:0]           reply_byte;
  logic [7:0]           cmd_pending;
  logic [1:0]           params_owed;
  logic [7:0]           len_lo;
  logic [7:0]           tconst;
  logic [SAMPLES_W-1:0] samples_owed;
  logic [8:0]           period_cnt;
  logic                 play_on;
  logic                 spk_on;
  logic [7:0]           dac_level;

  out_item_t   response_q[$];
  typed_resp_t typed_resp_q[$];
  dir_row_t    dir_rows[$];

  int unsigned tx_idle_pct = IDLE_PCT;
  int unsigned rx_idle_pct = IDLE_PCT;
  int unsigned hold_asked  = 0;
  int unsigned hold_done   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned n_sent      = 0;
  int unsigned n_beats     = 0;
  int unsigned n_dreq      = 0;
  int unsigned n_dac       = 0;
  int unsigned n_cfg       = 0;
  int unsigned errors      = 0;

  // Works out the response to one event beat and advances the model.
  function automatic out_item_t dsp_response(in_item_t it);
    logic [9:0] ofs;
    out_item_t  r;
    ofs = it.port_address - base_q;
    r = '0;
    r.read_data = IDLE_BYTE;
    case (it.action)
      ACT_IO_WRITE: begin
        if (ofs == OFS_RESET) begin
          if (it.write_data[0]) begin
            rst_held   = 1'b1;
            ready_flag = 1'b0;
          end else if (rst_held) begin
            // release: parser cleared, playback and speaker off, 0xAA queued
            rst_held    = 1'b0;
            cmd_pending = 8'h00;
            params_owed = 2'd0;
            play_on     = 1'b0;
            spk_on      = 1'b0;
            reply_byte  = RESET_REPLY;
            ready_flag  = 1'b1;
          end
        end else if (ofs == OFS_CMD && !rst_held) begin
          if (params_owed != 2'd0) begin
            if (cmd_pending == CMD_TC) begin
              tconst      = it.write_data;
              params_owed = 2'd0;
            end else if (cmd_pending == CMD_PLAY && params_owed == 2'd2) begin
              len_lo      = it.write_data;
              params_owed = 2'd1;
            end else begin
              // high length byte: start (or restart) the transfer
              samples_owed = {1'b0, it.write_data, len_lo} + ONE_SAMPLE;
              period_cnt   = 9'd256 - {1'b0, tconst};
              play_on      = 1'b1;
              params_owed  = 2'd0;
            end
          end else if (it.write_data == CMD_TC) begin
            cmd_pending = it.write_data;
            params_owed = 2'd1;
          end else if (it.write_data == CMD_PLAY) begin
            cmd_pending = it.write_data;
            params_owed = 2'd2;
          end else if (it.write_data == CMD_PAUSE) begin
            play_on = 1'b0;
          end else if (it.write_data == CMD_SPK_ON) begin
            spk_on = 1'b1;
          end else if (it.write_data == CMD_SPK_OFF) begin
            spk_on = 1'b0;
          end
        end
      end
      ACT_IO_READ: begin
        if (ofs == OFS_READ) begin
          r.read_data = reply_byte;
          ready_flag  = 1'b0;
        end else if (ofs == OFS_STATUS) begin
          r.read_data = (ready_flag ? FLAG_BIT : 8'h00) | LOW_BITS;
        end else if (ofs == OFS_CMD) begin
          r.read_data = LOW_BITS;
        end
      end
      ACT_TICK: begin
        // a zero period counter counts as expired
        if (play_on) begin
          if (period_cnt <= 9'd1) begin
            r.dma_request = 1'b1;
            period_cnt    = 9'd256 - {1'b0, tconst};
          end else begin
            period_cnt = period_cnt - 9'd1;
          end
        end
      end
      default: begin
        if (play_on && samples_owed != '0) begin
          dac_level    = it.sample_byte;
          r.dac_update = 1'b1;
          samples_owed = samples_owed - ONE_SAMPLE;
          if (samples_owed == '0) play_on = 1'b0;
        end
      end
    endcase
    r.dac_value  = dac_level;
    r.playing    = play_on;
    r.speaker_on = spk_on;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders; fields the action ignores carry random values
  // --------------------------------------------------------------------------
  function automatic in_item_t beat(action_e act, logic [9:0] port, logic [7:0] wd,
                                    logic [7:0] sb);
    in_item_t it;
    it.action       = act;
    it.port_address = port;
    it.write_data   = wd;
    it.sample_byte  = sb;
    return it;
  endfunction

  function automatic in_item_t wr_beat(logic [9:0] ofs, logic [7:0] b);
    return beat(ACT_IO_WRITE, base_q + ofs, b, 8'($urandom));
  endfunction

  function automatic in_item_t rd_beat(logic [9:0] ofs);
    return beat(ACT_IO_READ, base_q + ofs, 8'($urandom), 8'($urandom));
  endfunction

  function automatic in_item_t tick_beat();
    return beat(ACT_TICK, 10'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic in_item_t smp_beat(logic [7:0] b);
    return beat(ACT_DMA, 10'($urandom), 8'($urandom), b);
  endfunction

  function automatic in_item_t noise_beat();
    return beat(action_e'($urandom_range(3)), 10'($urandom), 8'($urandom),
                8'($urandom));
  endfunction

  function automatic out_item_t res(logic [7:0] rd, logic dreq, logic [7:0] dac,
                                    logic upd, logic play, logic spk);
    out_item_t r;
    r.read_data   = rd;
    r.dma_request = dreq;
    r.dac_value   = dac;
    r.dac_update  = upd;
    r.playing     = play;
    r.speaker_on  = spk;
    return r;
  endfunction

  task automatic add_row(in_item_t it, bit pinned = 1'b0, out_item_t val = '0);
    dir_row_t row;
    row.item   = it;
    row.pinned = pinned;
    row.val    = val;
    dir_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Sender: random idle cycles, then hold the beat until it is taken
  // --------------------------------------------------------------------------
  task automatic put(in_item_t it, bit pinned = 1'b0, out_item_t val = '0);
    typed_resp_t t;
    t.pinned = pinned;
    t.val    = val;
    typed_resp_q.push_back(t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Drop valid and wait until every response has come back, plus the latency.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (response_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(logic [9:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // wait so the model's base is settled before new beats are built
    @(posedge clk_i);
    n_cfg++;
  endtask

  // One random scenario: mostly well-formed driver sequences, some noise.
  task automatic random_burst();
    int unsigned pick;
    int unsigned steps;
    logic [7:0]  tc;
    logic [15:0] len_m1;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // playback: optional time constant, length, then ticks and DMA samples
      pick = $urandom_range(99);
      if (pick < 75)      tc = 8'($urandom_range(255, 240));
      else if (pick < 85) tc = 8'hFF;
      else if (pick < 90) tc = 8'h00;
      else                tc = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 80)      len_m1 = 16'($urandom_range(7));
      else if (pick < 95) len_m1 = 16'($urandom_range(40, 8));
      else                len_m1 = 16'($urandom);
      if ($urandom_range(3) != 0) begin
        put(wr_beat(OFS_CMD, CMD_TC));
        put(wr_beat(OFS_CMD, tc));
      end
      put(wr_beat(OFS_CMD, CMD_PLAY));
      put(wr_beat(OFS_CMD, len_m1[7:0]));
      put(wr_beat(OFS_CMD, len_m1[15:8]));
      steps = $urandom_range(40, 6);
      repeat (steps) begin
        pick = $urandom_range(99);
        if (pick < 45)      put(tick_beat());
        else if (pick < 72) put(smp_beat(8'($urandom)));
        else if (pick < 80) put(smp_beat($urandom_range(1) ? 8'hFF : 8'h00));
        else if (pick < 88) put(rd_beat($urandom_range(1) ? OFS_STATUS : OFS_CMD));
        else if (pick < 92) put(wr_beat(OFS_CMD, CMD_PAUSE));
        else if (pick < 95) put(wr_beat(OFS_CMD, 8'($urandom)));
        else                put(noise_beat());
      end
    end else if (pick < 55) begin
      // reset handshake, sometimes with a command while held
      put(wr_beat(OFS_RESET, {7'($urandom), 1'b1}));
      if ($urandom_range(1) != 0) put(rd_beat(OFS_STATUS));
      if ($urandom_range(2) == 0) put(wr_beat(OFS_CMD, CMD_SPK_ON));
      put(wr_beat(OFS_RESET, {7'($urandom), 1'b0}));
      put(rd_beat(OFS_STATUS));
      if ($urandom_range(3) != 0) put(rd_beat(OFS_READ));
      put(rd_beat(OFS_STATUS));
    end else if (pick < 65) begin
      pick = $urandom_range(4);
      case (pick)
        0:       put(wr_beat(OFS_CMD, CMD_SPK_ON));
        1:       put(wr_beat(OFS_CMD, CMD_SPK_OFF));
        2:       put(wr_beat(OFS_CMD, CMD_PAUSE));
        3: begin
          put(wr_beat(OFS_CMD, CMD_TC));
          put(wr_beat(OFS_CMD, 8'($urandom)));
        end
        default: put(wr_beat(OFS_CMD, 8'($urandom)));
      endcase
    end else if (pick < 82) begin
      // any offset of the window, decoded or not
      if ($urandom_range(1) != 0) put(rd_beat(10'($urandom_range(15))));
      else                        put(wr_beat(10'($urandom_range(15)), 8'($urandom)));
    end else begin
      put(noise_beat());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when the stimulus asks
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done   <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every output beat
  // --------------------------------------------------------------------------
  typed_resp_t mon_typed;
  out_item_t   mon_want;
  out_item_t   mon_got;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) base_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        mon_typed = typed_resp_q.pop_front();
        mon_want  = dsp_response(in_item_i);
        if (mon_typed.pinned) mon_want = mon_typed.val;
        response_q.push_back(mon_want);
        n_beats++;
        if (mon_want.dma_request) n_dreq++;
        if (mon_want.dac_update) n_dac++;
      end
      if (out_valid_o && out_ready_i) begin
        mon_got = out_item_o;
        if (response_q.size() == 0) begin
          errors++;
          $error("result beat with no response expected");
        end else begin
          mon_want = response_q.pop_front();
          check_field("read_data", mon_want.read_data, mon_got.read_data);
          check_field("dma_request", mon_want.dma_request, mon_got.dma_request);
          check_field("dac_value", mon_want.dac_value, mon_got.dac_value);
          check_field("dac_update", mon_want.dac_update, mon_got.dac_update);
          check_field("playing", mon_want.playing, mon_got.playing);
          check_field("speaker_on", mon_want.speaker_on, mon_got.speaker_on);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned goal;

    // model state after reset
    base_q       = BASE_RESET;
    rst_held     = 1'b0;
    ready_flag   = 1'b0;
    reply_byte   = 8'h00;
    cmd_pending  = 8'h00;
    params_owed  = 2'd0;
    len_lo       = 8'h00;
    tconst       = 8'h00;
    samples_owed = '0;
    period_cnt   = 9'd0;
    play_on      = 1'b0;
    spk_on       = 1'b0;
    dac_level    = DAC_MID;

    // Directed table at the reset base. Pinned rows carry a hand-written
    // response; the rest are left to the model.
    add_row(rd_beat(OFS_STATUS), 1'b1, res(LOW_BITS, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(rd_beat(OFS_CMD), 1'b1, res(LOW_BITS, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(rd_beat(OFS_RESET), 1'b1, res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    // undecoded address at the top of the I/O space
    add_row(beat(ACT_IO_READ, 10'h3FF, 8'h00, 8'hFF), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    // clear of the reset bit without a hold: nothing happens
    add_row(wr_beat(OFS_RESET, 8'h00), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(wr_beat(OFS_RESET, 8'hFF), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    // command while reset is held is dropped
    add_row(wr_beat(OFS_CMD, CMD_SPK_ON), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(wr_beat(OFS_RESET, 8'hFE), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(rd_beat(OFS_STATUS), 1'b1, res(8'hFF, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(rd_beat(OFS_READ), 1'b1, res(RESET_REPLY, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b0));
    add_row(wr_beat(OFS_CMD, CMD_SPK_ON), 1'b1,
            res(IDLE_BYTE, 1'b0, DAC_MID, 1'b0, 1'b0, 1'b1));
    // fastest rate, two samples
    add_row(wr_beat(OFS_CMD, CMD_TC));
    add_row(wr_beat(OFS_CMD, 8'hFF));
    add_row(wr_beat(OFS_CMD, CMD_PLAY));
    add_row(wr_beat(OFS_CMD, 8'h01));
    add_row(wr_beat(OFS_CMD, 8'h00));
    add_row(tick_beat());
    add_row(smp_beat(8'hFF));
    // restart while playing with the longest length
    add_row(wr_beat(OFS_CMD, CMD_PLAY));
    add_row(wr_beat(OFS_CMD, 8'hFF));
    add_row(wr_beat(OFS_CMD, 8'hFF));
    add_row(smp_beat(8'h00));
    add_row(wr_beat(OFS_CMD, CMD_PAUSE));
    // sample after pause is ignored; unknown command; speaker off
    add_row(smp_beat(8'h55));
    add_row(wr_beat(OFS_CMD, 8'h37));
    add_row(wr_beat(OFS_CMD, CMD_SPK_OFF));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) put(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].val);
    settle();

    // reset base, normal idling
    while (n_sent < 130) random_burst();
    settle();

    // lowest base, long stretch with no idling on either side
    write_base(10'h200);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (n_sent < 240) random_burst();
    settle();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;

    // highest base; receiver holds off while the sender keeps pushing
    write_base(10'h3F0);
    hold_asked++;
    tx_idle_pct = 0;
    goal = n_sent + 30;
    while (n_sent < goal) random_burst();
    tx_idle_pct = IDLE_PCT;
    while (n_sent < 350) random_burst();
    settle();

    // arbitrary base within the legal range
    write_base(10'($urandom_range(1008, 512)));
    while (n_sent < 460) random_burst();
    settle();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d event beats over four base-port settings (%0d writes).",
             n_beats, n_cfg);
    $display("Responses included %0d DMA requests and %0d DAC updates; %0d mismatches.",
             n_dreq, n_dac, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sound_dsp_command_interface_core.f
+incdir+hw/rtl
hw/rtl/sdci_pkg.sv
hw/rtl/sdci_front.sv
hw/rtl/sdci_queue.sv
hw/rtl/sdci_back.sv
hw/rtl/sound_dsp_command_interface_core.sv
tb/sound_dsp_command_interface_core_tb.sv
